### design/ffra_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the first-fit range allocator.
package ffra_pkg;

	localparam int SPACE_W = 8;
	localparam int DATA_W  = 32;
	// candidate base can reach 2^33-2, plus a 32-bit length
	localparam int END_W   = DATA_W + 2;

	typedef enum logic [1:0] {
		FN_PUT   = 2'd0,
		FN_DROP  = 2'd1,
		FN_ALLOC = 2'd2
	} func_t;

	typedef struct packed {
		logic               valid;
		logic [SPACE_W-1:0] space;
		logic [DATA_W-1:0]  base;
		logic [DATA_W-1:0]  size;
	} entry_t;

	typedef enum logic [2:0] {
		MEM_NONE  = 3'd0,
		MEM_CLEAR = 3'd1,
		MEM_PUT   = 3'd2,
		MEM_ALLOC = 3'd3,
		MEM_DROP  = 3'd4
	} mem_op_t;

	typedef enum logic [1:0] {
		RES_ZERO  = 2'd0,
		RES_FAIL  = 2'd1,
		RES_START = 2'd2,
		RES_CAND  = 2'd3
	} res_sel_t;

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_EXEC  = 6'b000100,
		S_PASS  = 6'b001000,
		S_SCAN  = 6'b010000,
		S_RESP  = 6'b100000
	} state_t;

	typedef struct packed {
		mem_op_t  mem_op;
		logic     capture;
		logic     cand_init;
		logic     cand_move;
		logic     pass_start;
		logic     idx_clr;
		logic     idx_inc;
		logic     res_load;
		res_sel_t res_sel;
	} cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       slot_ok;
		logic       limit_ok;
		logic       conflict;
		logic       idx_last;
		logic       pass_last;
	} status_t;

endpackage

### design/ffra_dp.sv
`timescale 1ns / 1ps
// Datapath: item registers, range table memory, candidate search and result registers.
module ffra_dp import ffra_pkg::*; #(
	parameter int SLOTS     = 16,
	parameter int ADDR_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         func,
	input  logic [3:0]         slot,
	input  logic [SPACE_W-1:0] space_id,
	input  logic [DATA_W-1:0]  start_req,
	input  logic [DATA_W-1:0]  length,
	input  cmd_t               cmd,
	output status_t            st,
	output logic [DATA_W-1:0]  placed_base,
	output logic               failed
);

	localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int PASS_W = $clog2(SLOTS + 1);
	localparam logic [END_W:0] LIMIT = (ADDR_BITS >= END_W) ? {(END_W + 1){1'b1}}
		: ((END_W + 1)'(1) << ADDR_BITS);

	entry_t mem [SLOTS];

	logic [1:0]         func_q;
	logic [3:0]         slot_q;
	logic [SPACE_W-1:0] space_q;
	logic [DATA_W-1:0]  start_q;
	logic [DATA_W-1:0]  len_q;
	logic [IDX_W-1:0]   idx_q;
	logic [PASS_W-1:0]  pass_q;
	logic [DATA_W:0]    cand_q;
	logic [END_W-1:0]   cand_end_q;
	entry_t             rd_q;
	logic [DATA_W-1:0]  placed_base_q;
	logic               failed_q;

	logic [IDX_W-1:0]   self_idx;
	logic [IDX_W-1:0]   rd_addr;
	logic [IDX_W-1:0]   wr_addr;
	logic               wr_en;
	entry_t             wr_data;
	logic [END_W-1:0]   end_now;
	logic [DATA_W:0]    hi;

	assign self_idx = IDX_W'(slot_q);
	assign end_now  = END_W'(cand_q) + END_W'(len_q);
	assign hi       = (DATA_W + 1)'(rd_q.base) + (DATA_W + 1)'(rd_q.size);
	assign rd_addr  = cmd.pass_start ? '0 : idx_q + IDX_W'(1);

	assign st.func      = func_q;
	assign st.slot_ok   = (32'(slot_q) < 32'(SLOTS));
	assign st.limit_ok  = ({1'b0, end_now} <= LIMIT) && !cand_q[DATA_W];
	// half-open overlap against the entry read last cycle
	assign st.conflict  = rd_q.valid && (idx_q != self_idx) && (rd_q.space == space_q)
		&& (cand_q < hi) && (END_W'(rd_q.base) < cand_end_q);
	assign st.idx_last  = (idx_q == IDX_W'(SLOTS - 1));
	assign st.pass_last = (pass_q == PASS_W'(SLOTS));

	always_comb begin
		wr_en   = 1'b1;
		wr_addr = self_idx;
		wr_data = '0;
		case (cmd.mem_op)
			MEM_CLEAR: begin
				wr_addr = idx_q;
			end
			MEM_PUT: begin
				wr_data = '{valid: 1'b1, space: space_q, base: start_q, size: len_q};
			end
			MEM_ALLOC: begin
				wr_data = '{valid: 1'b1, space: space_q, base: cand_q[DATA_W-1:0],
					size: len_q};
			end
			MEM_DROP: begin
				wr_data = '0;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q  <= func;
			slot_q  <= slot;
			space_q <= space_id;
			start_q <= start_req;
			len_q   <= length;
		end
		if (cmd.cand_init) begin
			cand_q <= {1'b0, start_q};
		end else if (cmd.cand_move) begin
			cand_q <= hi;
		end
		if (cmd.pass_start) begin
			cand_end_q <= end_now;
		end
		if (cmd.res_load) begin
			case (cmd.res_sel)
				RES_FAIL: begin
					placed_base_q <= '0;
					failed_q      <= 1'b1;
				end
				RES_START: begin
					placed_base_q <= start_q;
					failed_q      <= 1'b0;
				end
				RES_CAND: begin
					placed_base_q <= cand_q[DATA_W-1:0];
					failed_q      <= 1'b0;
				end
				default: begin
					placed_base_q <= '0;
					failed_q      <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			pass_q <= '0;
		end else begin
			if (cmd.idx_clr || cmd.pass_start) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (cmd.cand_init) begin
				pass_q <= '0;
			end else if (cmd.cand_move) begin
				pass_q <= pass_q + PASS_W'(1);
			end
		end
	end

	assign placed_base = placed_base_q;
	assign failed      = failed_q;

endmodule

### design/ffra_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences table clearing, item execution, the first-fit scan and the result beat.
module ffra_ctrl import ffra_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	input  status_t st,
	output cmd_t    cmd
);

	state_t   state_q, state_d;
	res_sel_t res_sel_q, res_sel_d;
	logic     out_valid_q;
	logic     out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d   = state_q;
		res_sel_d = res_sel_q;
		cmd       = '{mem_op: MEM_NONE, res_sel: res_sel_q, default: 1'b0};
		unique case (state_q)
			S_CLEAR: begin
				cmd.mem_op  = MEM_CLEAR;
				cmd.idx_inc = 1'b1;
				if (st.idx_last) begin
					cmd.idx_clr = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d   = S_RESP;
				res_sel_d = RES_ZERO;
				if (!st.slot_ok) begin
					res_sel_d = RES_FAIL;
				end else begin
					case (st.func)
						FN_PUT: begin
							cmd.mem_op = MEM_PUT;
							res_sel_d  = RES_START;
						end
						FN_DROP: begin
							cmd.mem_op = MEM_DROP;
						end
						FN_ALLOC: begin
							cmd.cand_init = 1'b1;
							state_d       = S_PASS;
						end
						default: begin
							res_sel_d = RES_ZERO;
						end
					endcase
				end
			end
			S_PASS: begin
				if (!st.limit_ok) begin
					res_sel_d = RES_FAIL;
					state_d   = S_RESP;
				end else begin
					cmd.pass_start = 1'b1;
					state_d        = S_SCAN;
				end
			end
			S_SCAN: begin
				if (st.conflict) begin
					// jump past the blocking range and rescan, unless passes ran out
					if (st.pass_last) begin
						res_sel_d = RES_FAIL;
						state_d   = S_RESP;
					end else begin
						cmd.cand_move = 1'b1;
						state_d       = S_PASS;
					end
				end else if (st.idx_last) begin
					cmd.mem_op = MEM_ALLOC;
					res_sel_d  = RES_CAND;
					state_d    = S_RESP;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_RESP: begin
				if (out_free) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			res_sel_q   <= RES_ZERO;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			res_sel_q <= res_sel_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### design/first_fit_range_allocator.sv
`timescale 1ns / 1ps
// First-fit address range allocator: top level joining controller and datapath.
//
// Input channel (in_valid / in_stall) carries one item per beat: func selects write of a
// placed range, clear of a slot, or allocation starting at start_req. Output channel
// (out_valid / out_stall) returns one beat per item: placed_base and failed.
// After reset the table memory is swept once, one entry a cycle, with in_stall held high
// until the sweep ends. Items are handled one at a time.
// Write, clear, bad slot or unknown func: the item is captured in S_IDLE, executed in
// S_EXEC and its result loaded from S_RESP. Allocation adds scan passes between S_EXEC
// and S_RESP (the first, plus one after each conflict met, at most SLOTS + 1), each
// reading up to SLOTS entries, one entry per cycle from the table's single read port.
// The result sits in an output register; while out_stall is high it holds, and the
// block still takes the next item and works on it, waiting only to present that next
// result until the register is free.
module first_fit_range_allocator import ffra_pkg::*; #(
	parameter int SLOTS     = 16,
	parameter int ADDR_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         func,
	input  logic [3:0]         slot,
	input  logic [SPACE_W-1:0] space_id,
	input  logic [DATA_W-1:0]  start_req,
	input  logic [DATA_W-1:0]  length,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [DATA_W-1:0]  placed_base,
	output logic               failed
);

	cmd_t    cmd;
	status_t st;

	ffra_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.st        (st),
		.cmd       (cmd)
	);

	ffra_dp #(
		.SLOTS     (SLOTS),
		.ADDR_BITS (ADDR_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.func        (func),
		.slot        (slot),
		.space_id    (space_id),
		.start_req   (start_req),
		.length      (length),
		.cmd         (cmd),
		.st          (st),
		.placed_base (placed_base),
		.failed      (failed)
	);

endmodule

### design/ffra_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the first-fit range allocator, bound to the top level.
module ffra_checker import ffra_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic [1:0]         func,
	input logic [3:0]         slot,
	input logic [SPACE_W-1:0] space_id,
	input logic [DATA_W-1:0]  start_req,
	input logic [DATA_W-1:0]  length,
	input logic               out_valid,
	input logic               out_stall,
	input logic [DATA_W-1:0]  placed_base,
	input logic               failed
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(placed_base) && $stable(failed))
		else $error("result beat changed under stall");

	// a failed beat never carries a base
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && failed |-> placed_base == '0)
		else $error("failed result with nonzero base");

	// one item at a time: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken while busy");

	// no result appears in the cycle after an accept
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("result raised too early");

endmodule

bind first_fit_range_allocator ffra_checker u_ffra_checker (.*);
